>>> src/mmul_pkg.sv
// mmul_pkg: sizes, widths and shared types for the 4x4 fixed-point matrix multiplier
// no dependencies; used by mmul_cell, mmul_ctrl and matrix_multiply_4x4
`timescale 1ns / 1ps

package mmul_pkg;

  // matrix geometry and number format
  localparam int DIM       = 4;
  localparam int FRAC_BITS = 16;
  localparam int CELLS     = DIM * DIM;

  // datapath widths
  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int SUM_W     = PROD_W + $clog2(DIM);
  localparam int ROW_W     = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int IDX_W     = $clog2(CELLS);
  localparam int OUT_IDX_W = 4;

  // operand write bus from the load side into every cell
  typedef struct packed {
    logic                     we;
    logic [ROW_W-1:0]         row;
    logic [ROW_W-1:0]         col;
    logic signed [DATA_W-1:0] left;
    logic signed [DATA_W-1:0] right;
  } wr_t;

  // product element token that walks down the cell chain
  typedef struct packed {
    logic             vld;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] col;
    logic [IDX_W-1:0] idx;
  } tok_t;

endpackage

>>> src/mmul_cell.sv
// mmul_cell: one multiply-accumulate cell of the chain, holds column k of A and row k of B
// depends on mmul_pkg
`timescale 1ns / 1ps

module mmul_cell (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [mmul_pkg::ROW_W-1:0]         cell_id,
  input  logic                               adv,
  input  mmul_pkg::wr_t                      wr,
  input  mmul_pkg::tok_t                     tok_in,
  input  logic signed [mmul_pkg::SUM_W-1:0]  sum_in,
  output mmul_pkg::tok_t                     tok_out,
  output logic signed [mmul_pkg::SUM_W-1:0]  sum_out
);

  // local operand stores: a_mem[row] = A(row, k), b_mem[col] = B(k, col)
  logic signed [mmul_pkg::DATA_W-1:0] a_mem [mmul_pkg::DIM];
  logic signed [mmul_pkg::DATA_W-1:0] b_mem [mmul_pkg::DIM];

  mmul_pkg::tok_t                     tok_r;
  logic signed [mmul_pkg::PROD_W-1:0] prod_r;
  logic signed [mmul_pkg::SUM_W-1:0]  psum_r;

  // operand writes during loading
  always_ff @(posedge clk) begin
    if (wr.we && (wr.col == cell_id)) begin
      a_mem[wr.row] <= wr.left;
    end
    if (wr.we && (wr.row == cell_id)) begin
      b_mem[wr.col] <= wr.right;
    end
  end

  // token register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else if (adv) begin
      tok_r <= tok_in;
    end
  end

  // product and incoming partial sum
  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= mmul_pkg::PROD_W'(a_mem[tok_in.row]) * mmul_pkg::PROD_W'(b_mem[tok_in.col]);
      psum_r <= sum_in;
    end
  end

  // hand accumulated sum to the next cell
  assign sum_out = psum_r + mmul_pkg::SUM_W'(prod_r);
  assign tok_out = tok_r;

endmodule

>>> src/mmul_ctrl.sv
// mmul_ctrl: load position counter and product element sequencer
// depends on mmul_pkg
`timescale 1ns / 1ps

module mmul_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [mmul_pkg::DATA_W-1:0] in_left,
  input  logic signed [mmul_pkg::DATA_W-1:0] in_right,
  input  logic                              adv,
  input  logic                              done,
  output mmul_pkg::wr_t                     wr,
  output mmul_pkg::tok_t                    tok
);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_EMIT,
    ST_DRAIN
  } state_t;

  localparam logic [mmul_pkg::ROW_W-1:0] LAST_RC = mmul_pkg::ROW_W'(mmul_pkg::DIM - 1);

  state_t                     state_r;
  logic [mmul_pkg::ROW_W-1:0] lrow_r, lcol_r;
  logic [mmul_pkg::ROW_W-1:0] erow_r, ecol_r;
  logic [mmul_pkg::IDX_W-1:0] eidx_r;
  logic                       in_fire;
  logic                       load_last;
  logic                       emit_last;

  assign in_ready  = (state_r == ST_LOAD);
  assign in_fire   = in_valid && in_ready;
  assign load_last = (lrow_r == LAST_RC) && (lcol_r == LAST_RC);
  assign emit_last = (erow_r == LAST_RC) && (ecol_r == LAST_RC);

  // write bus into the cells
  assign wr.we    = in_fire;
  assign wr.row   = lrow_r;
  assign wr.col   = lcol_r;
  assign wr.left  = in_left;
  assign wr.right = in_right;

  // token into the head of the chain
  assign tok.vld = (state_r == ST_EMIT);
  assign tok.row = erow_r;
  assign tok.col = ecol_r;
  assign tok.idx = eidx_r;

  // state, load position and emit position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      lrow_r  <= '0;
      lcol_r  <= '0;
      erow_r  <= '0;
      ecol_r  <= '0;
      eidx_r  <= '0;
    end else begin
      case (state_r)
        ST_LOAD: begin
          if (in_fire) begin
            if (lrow_r == LAST_RC) begin
              lrow_r <= '0;
              lcol_r <= load_last ? '0 : lcol_r + 1'b1;
            end else begin
              lrow_r <= lrow_r + 1'b1;
            end
            if (load_last) begin
              state_r <= ST_EMIT;
              erow_r  <= '0;
              ecol_r  <= '0;
              eidx_r  <= '0;
            end
          end
        end
        ST_EMIT: begin
          if (adv) begin
            eidx_r <= eidx_r + 1'b1;
            if (erow_r == LAST_RC) begin
              erow_r <= '0;
              ecol_r <= ecol_r + 1'b1;
            end else begin
              erow_r <= erow_r + 1'b1;
            end
            if (emit_last) begin
              state_r <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (done) begin
            state_r <= ST_LOAD;
          end
        end
        default: begin
          state_r <= ST_LOAD;
        end
      endcase
    end
  end

  // the request that completes a pair starts the sequencer
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && load_last |=> tok.vld && (eidx_r == '0))
    else $error("sequencer did not start after final load request");

  // no loading while products are issued
  a_no_load_emit: assert property (@(posedge clk) disable iff (!rst_n)
    tok.vld |-> !in_ready)
    else $error("load accepted while emitting");

endmodule

>>> src/matrix_multiply_4x4.sv
// matrix_multiply_4x4: 4x4 Q16.16 matrix product; loads 16 requests, then emits 16 elements.
// The chain of DIM multiply-accumulate cells takes one product element per cycle while out_ready
// does not hold the output register; a new pair loads only after the last element is taken.
// Reset (rst_n, sync, active low) clears counters and valids; operand stores are not cleared.
// depends on mmul_pkg, mmul_cell, mmul_ctrl
`timescale 1ns / 1ps

module matrix_multiply_4x4 (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [mmul_pkg::DATA_W-1:0]    in_left_element,
  input  logic signed [mmul_pkg::DATA_W-1:0]    in_right_element,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [mmul_pkg::DATA_W-1:0]    out_product_element,
  output logic [mmul_pkg::OUT_IDX_W-1:0]        out_element_index,
  output logic                                  out_last_element
);

  localparam logic signed [mmul_pkg::DATA_W-1:0] SAT_MAX = {1'b0, {(mmul_pkg::DATA_W-1){1'b1}}};
  localparam logic signed [mmul_pkg::DATA_W-1:0] SAT_MIN = {1'b1, {(mmul_pkg::DATA_W-1){1'b0}}};

  mmul_pkg::wr_t                     wr;
  mmul_pkg::tok_t                    tok [mmul_pkg::DIM + 1];
  logic signed [mmul_pkg::SUM_W-1:0] sum [mmul_pkg::DIM + 1];
  logic                              adv;
  logic                              done;
  logic signed [mmul_pkg::SUM_W-1:0] shifted;
  logic signed [mmul_pkg::DATA_W-1:0] sat_val;

  logic                               out_valid_r;
  logic signed [mmul_pkg::DATA_W-1:0] out_data_r;
  logic [mmul_pkg::OUT_IDX_W-1:0]     out_idx_r;
  logic                               out_last_r;

  // whole chain moves unless the output register is held
  assign adv  = !out_valid_r || out_ready;
  assign done = out_valid_r && out_ready && out_last_r;

  mmul_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_left  (in_left_element),
    .in_right (in_right_element),
    .adv      (adv),
    .done     (done),
    .wr       (wr),
    .tok      (tok[0])
  );

  assign sum[0] = '0;

  // chain of multiply-accumulate cells
  for (genvar k = 0; k < mmul_pkg::DIM; k++) begin : g_cell
    mmul_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cell_id (mmul_pkg::ROW_W'(k)),
      .adv     (adv),
      .wr      (wr),
      .tok_in  (tok[k]),
      .sum_in  (sum[k]),
      .tok_out (tok[k+1]),
      .sum_out (sum[k+1])
    );
  end

  // floor shift and saturate to 32 bits
  always_comb begin
    shifted = sum[mmul_pkg::DIM] >>> mmul_pkg::FRAC_BITS;
    if (shifted > mmul_pkg::SUM_W'(SAT_MAX)) begin
      sat_val = SAT_MAX;
    end else if (shifted < mmul_pkg::SUM_W'(SAT_MIN)) begin
      sat_val = SAT_MIN;
    end else begin
      sat_val = shifted[mmul_pkg::DATA_W-1:0];
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= tok[mmul_pkg::DIM].vld;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= sat_val;
      out_idx_r  <= mmul_pkg::OUT_IDX_W'(tok[mmul_pkg::DIM].idx);
      out_last_r <= (tok[mmul_pkg::DIM].idx == mmul_pkg::IDX_W'(mmul_pkg::CELLS - 1));
    end
  end

  assign out_valid           = out_valid_r;
  assign out_product_element = out_data_r;
  assign out_element_index   = out_idx_r;
  assign out_last_element    = out_last_r;

  // loading and emitting never overlap
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("result pending while loading");

  // product elements leave in ascending order
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_element |=>
      !out_valid ||
      (out_element_index == mmul_pkg::OUT_IDX_W'($past(out_element_index) + 1'b1)))
    else $error("product element out of order");

endmodule
